[rtl/core/comment_header_validator_assert.svh]
// ---------------------------------------------------------------------------
// Comment header validator assertion macros
// Assertion wrappers shared by the validator RTL; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef COMMENT_HEADER_VALIDATOR_ASSERT_SVH
`define COMMENT_HEADER_VALIDATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define CHV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define CHV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CHV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define CHV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/core/chv_pkg.sv]
// ---------------------------------------------------------------------------
// Comment header validator package
// Shared codes, result structure and the magic text of the packet.
// ---------------------------------------------------------------------------
package chv_pkg;

   localparam logic [4:0] MIN_PACKET = 5'd16;

   typedef enum logic [2:0] {
      ROLE_MAGIC        = 3'd0,
      ROLE_VENDOR_LEN   = 3'd1,
      ROLE_VENDOR_TEXT  = 3'd2,
      ROLE_COUNT        = 3'd3,
      ROLE_COMMENT_LEN  = 3'd4,
      ROLE_COMMENT_TEXT = 3'd5,
      ROLE_IGNORED      = 3'd6
   } role_type;

   typedef enum logic [2:0] {
      VERDICT_PENDING   = 3'd0,
      VERDICT_ACCEPTED  = 3'd1,
      VERDICT_TOO_SHORT = 3'd2,
      VERDICT_BAD_MAGIC = 3'd3,
      VERDICT_TRUNCATED = 3'd4,
      VERDICT_TRAILING  = 3'd5
   } verdict_type;

   typedef struct packed {
      role_type    role;
      logic [31:0] comment_number;
      logic [31:0] length_value;
      logic        length_ready;
      verdict_type verdict;
      logic        packet_done;
   } result_type;

   // Expected magic text, one byte per position.
   function automatic logic [7:0] magic_byte(input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd0:    b = 8'h4F; // O
         3'd1:    b = 8'h70; // p
         3'd2:    b = 8'h75; // u
         3'd3:    b = 8'h73; // s
         3'd4:    b = 8'h54; // T
         3'd5:    b = 8'h61; // a
         3'd6:    b = 8'h67; // g
         default: b = 8'h73; // s
      endcase
      return b;
   endfunction

endpackage

[rtl/core/chv_parser.sv]
// ---------------------------------------------------------------------------
// Comment header parser core
// Holds the parse state and works out the result for one byte per step.
// ---------------------------------------------------------------------------
module chv_parser
   import chv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   output result_type  result
);

   typedef enum logic [2:0] {
      PH_MAGIC = 3'd0,
      PH_VLEN  = 3'd1,
      PH_VTEXT = 3'd2,
      PH_COUNT = 3'd3,
      PH_CLEN  = 3'd4,
      PH_CTEXT = 3'd5,
      PH_TAIL  = 3'd6,
      PH_END   = 3'd7
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  magic_pos_ff, magic_pos_in;
   logic [1:0]  field_pos_ff, field_pos_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] skip_ff, skip_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] counter_ff, counter_in;
   logic [4:0]  seen_ff, seen_in;
   verdict_type error_ff, error_in;

   logic [31:0] merged;
   logic [31:0] counter_plus;
   logic [31:0] skip_minus;
   phase_type   after_comment;

   assign merged       = shift_ff | (32'(data_byte) << {field_pos_ff, 3'b000});
   assign counter_plus = counter_ff + 32'd1;
   assign skip_minus   = skip_ff - 32'd1;
   assign after_comment = (counter_plus == total_ff) ? PH_END : PH_CLEN;

   always_comb begin
      phase_in     = phase_ff;
      magic_pos_in = magic_pos_ff;
      field_pos_in = field_pos_ff;
      shift_in     = shift_ff;
      skip_in      = skip_ff;
      total_in     = total_ff;
      counter_in   = counter_ff;
      error_in     = error_ff;
      seen_in      = (seen_ff < MIN_PACKET) ? seen_ff + 5'd1 : seen_ff;

      result.role           = ROLE_IGNORED;
      result.comment_number = '0;
      result.length_value   = '0;
      result.length_ready   = 1'b0;
      result.verdict        = VERDICT_PENDING;
      result.packet_done    = last_byte;

      case (phase_ff)
         PH_MAGIC: begin
            result.role = ROLE_MAGIC;
            if (data_byte != magic_byte(magic_pos_ff) && error_ff == VERDICT_PENDING) begin
               error_in = VERDICT_BAD_MAGIC;
            end
            magic_pos_in = magic_pos_ff + 3'd1;
            if (magic_pos_ff == 3'd7) begin
               phase_in     = PH_VLEN;
               field_pos_in = '0;
               shift_in     = '0;
            end
         end
         PH_VLEN, PH_COUNT, PH_CLEN: begin
            case (phase_ff)
               PH_VLEN:  result.role = ROLE_VENDOR_LEN;
               PH_COUNT: result.role = ROLE_COUNT;
               default:  result.role = ROLE_COMMENT_LEN;
            endcase
            if (phase_ff == PH_CLEN) begin
               result.comment_number = counter_ff;
            end
            result.length_value = merged;
            shift_in            = merged;
            if (field_pos_ff == 2'd3) begin
               result.length_ready = 1'b1;
               field_pos_in        = '0;
               shift_in            = '0;
               case (phase_ff)
                  PH_VLEN: begin
                     skip_in  = merged;
                     phase_in = (merged == '0) ? PH_COUNT : PH_VTEXT;
                  end
                  PH_COUNT: begin
                     total_in   = merged;
                     counter_in = '0;
                     phase_in   = (merged == '0) ? PH_TAIL : PH_CLEN;
                  end
                  default: begin
                     skip_in = merged;
                     if (merged == '0) begin
                        counter_in = counter_plus;
                        phase_in   = after_comment;
                     end else begin
                        phase_in = PH_CTEXT;
                     end
                  end
               endcase
            end else begin
               field_pos_in = field_pos_ff + 2'd1;
            end
         end
         PH_VTEXT: begin
            result.role = ROLE_VENDOR_TEXT;
            skip_in     = skip_minus;
            if (skip_minus == '0) begin
               phase_in = PH_COUNT;
            end
         end
         PH_CTEXT: begin
            result.role           = ROLE_COMMENT_TEXT;
            result.comment_number = counter_ff;
            skip_in               = skip_minus;
            if (skip_minus == '0) begin
               counter_in = counter_plus;
               phase_in   = after_comment;
            end
         end
         PH_TAIL: begin
            result.role = ROLE_IGNORED;
         end
         default: begin
            // Any byte after the final comment is surplus.
            result.role = ROLE_IGNORED;
            if (error_ff == VERDICT_PENDING) begin
               error_in = VERDICT_TRAILING;
            end
         end
      endcase

      if (last_byte) begin
         if (seen_in < MIN_PACKET) begin
            result.verdict = VERDICT_TOO_SHORT;
         end else if (error_in != VERDICT_PENDING) begin
            result.verdict = error_in;
         end else if (phase_in == PH_TAIL || phase_in == PH_END) begin
            result.verdict = VERDICT_ACCEPTED;
         end else begin
            result.verdict = VERDICT_TRUNCATED;
         end
         // The packet is finished: start the next one from scratch.
         phase_in     = PH_MAGIC;
         magic_pos_in = '0;
         field_pos_in = '0;
         shift_in     = '0;
         skip_in      = '0;
         total_in     = '0;
         counter_in   = '0;
         seen_in      = '0;
         error_in     = VERDICT_PENDING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         magic_pos_ff <= '0;
         field_pos_ff <= '0;
         shift_ff     <= '0;
         skip_ff      <= '0;
         total_ff     <= '0;
         counter_ff   <= '0;
         seen_ff      <= '0;
         error_ff     <= VERDICT_PENDING;
      end else if (step) begin
         phase_ff     <= phase_in;
         magic_pos_ff <= magic_pos_in;
         field_pos_ff <= field_pos_in;
         shift_ff     <= shift_in;
         skip_ff      <= skip_in;
         total_ff     <= total_in;
         counter_ff   <= counter_in;
         seen_ff      <= seen_in;
         error_ff     <= error_in;
      end
   end

endmodule

[rtl/core/comment_header_validator.sv]
// ---------------------------------------------------------------------------
// Comment header validator
// Streams a comment-header packet byte by byte and tags every byte.
// ---------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one packet byte per item, with req_last_byte
//   set on the final byte. The rsp_ channel returns exactly one item per
//   byte: its role, comment index, assembled length value and, on the final
//   byte, the verdict for the whole packet.
//   An item is taken when valid is high and stall is low.
//   rsp_valid rises once an accepted byte has passed the input register and
//   then the parse logic into the result register; a held rsp_stall can
//   delay it. Throughput is one item per cycle while rsp_stall is low, set
//   by the single state update per byte in the parser.
//   When rsp_stall is held the result register keeps its item, the input
//   register fills, and req_stall rises only once both are occupied.
//   Reset empties both registers and returns the parser to the start of a
//   packet; the final byte of every packet does the same for the parser.
// ---------------------------------------------------------------------------
`include "comment_header_validator_assert.svh"

module comment_header_validator
   import chv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_byte_role,
   output logic [31:0] rsp_comment_number,
   output logic [31:0] rsp_length_value,
   output logic        rsp_length_ready,
   output logic [2:0]  rsp_verdict,
   output logic        rsp_packet_done
);

   logic       hold_valid_ff;
   logic [7:0] hold_byte_ff;
   logic       hold_last_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type parsed;
   logic       advance;
   logic       accept;

   assign advance   = hold_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = hold_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   chv_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (hold_byte_ff),
      .last_byte (hold_last_ff),
      .result    (parsed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            hold_valid_ff <= 1'b1;
         end else if (advance) begin
            hold_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         hold_byte_ff <= req_data_byte;
         hold_last_ff <= req_last_byte;
      end
      if (advance) begin
         out_ff <= parsed;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_byte_role      = out_ff.role;
   assign rsp_comment_number = out_ff.comment_number;
   assign rsp_length_value   = out_ff.length_value;
   assign rsp_length_ready   = out_ff.length_ready;
   assign rsp_verdict        = out_ff.verdict;
   assign rsp_packet_done    = out_ff.packet_done;

   `CHV_ASSERT_NEXT(a_last_reaches_out, clock, reset, advance && hold_last_ff, rsp_valid && rsp_packet_done, "final byte did not produce a done result")
   `CHV_ASSERT_IMPL(a_verdict_only_at_end, clock, reset, rsp_valid && !rsp_packet_done, rsp_verdict == VERDICT_PENDING, "verdict given before the final byte")
   `CHV_ASSERT_IMPL(a_ready_on_length, clock, reset, rsp_valid && rsp_length_ready, rsp_byte_role == ROLE_VENDOR_LEN || rsp_byte_role == ROLE_COUNT || rsp_byte_role == ROLE_COMMENT_LEN, "length ready on a byte outside a length field")
   `CHV_ASSERT_IMPL(a_stall_only_when_full, clock, reset, req_stall, hold_valid_ff && out_valid_ff && rsp_stall, "input stalled while a register was free")

endmodule
